>>> sv/lis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest increasing subsequence: shared package
// Payload types, storage entry types, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package lis_pkg;

   // Field widths fixed by the transaction formats.
   localparam int VALUE_W = 32;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;

   // Predecessor code that marks the start of a run.
   localparam logic [CNT_W-1:0] NO_PRED = CNT_W'(64);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      final_item;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic [IDX_W-1:0]          element_index;
      logic [CNT_W-1:0]          run_length;
      logic                      overflowed;
      logic                      run_end;
   } rsp_type;

   // One stored input item: its value and the position of its predecessor.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [CNT_W-1:0]          predecessor;
   } item_entry_type;

   // One tail slot: smallest tail value for a run length and its item position.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          index;
   } tail_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_WALK_START,
      ST_WALK,
      ST_EMIT_CHAIN,
      ST_EMIT_ITEM,
      ST_EMIT_LOAD
   } state_type;

endpackage : lis_pkg
`default_nettype wire

>>> sv/lis_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest increasing subsequence: generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : lis_ram
`default_nettype wire

>>> sv/longest_increasing_subsequence_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Longest increasing subsequence: top level
// Tail-array method with a lower-bound binary search per item, predecessor
// links per item and a backward walk that is replayed in forward order.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Contents
//   req_      in         req_valid/req_ready   req_type: value, final_item
//   rsp_      out        rsp_valid/rsp_ready   rsp_type: one subsequence member
//
// A stored item is placed by a lower-bound binary search through the tail
// RAM, one registered read per step and none while no tail is stored, and is
// then written. An item beyond capacity is not stored. A final item then
// starts the predecessor walk and emits each result while the sink is ready.
// Reset clears the state, counters and flags only; the RAMs are not cleared.
// The input side is stalled from acceptance until the sequencer is idle again.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_top #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lis_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lis_pkg::rsp_type      rsp_payload
);

   import lis_pkg::*;

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_ITEMS);

   // Control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] tail_count_ff, tail_count_in;
   logic [CNT_W-1:0] item_count_ff, item_count_in;
   logic [CNT_W-1:0] best_length_ff, best_length_in;
   logic [IDX_W-1:0] best_index_ff, best_index_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      final_ff, final_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi_ff, hi_in;
   logic [CNT_W-1:0]          mid_ff, mid_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          walk_n_ff, walk_n_in;
   logic [CNT_W-1:0]          emit_k_ff, emit_k_in;
   rsp_type                   rsp_ff, rsp_in;

   // RAM ports
   logic             item_wr_en, tail_wr_en, chain_wr_en;
   logic [CNT_W-1:0] item_wr_addr, tail_wr_addr, chain_wr_addr;
   logic [CNT_W-1:0] item_rd_addr, tail_rd_addr, chain_rd_addr;
   item_entry_type   item_wr, item_rd;
   tail_entry_type   tail_wr, tail_rd;
   logic [IDX_W-1:0] chain_wr, chain_rd;

   // Search datapath
   logic             cmp_le;
   logic [CNT_W-1:0] lo_step, hi_step, mid_step, mid_first;
   logic [CNT_W:0]   step_sum, first_sum;
   logic [CNT_W-1:0] pos_plus;
   logic [CNT_W-1:0] walk_cur;
   logic             walk_go;

   // Item values with predecessor links.
   lis_ram #(
      .WIDTH ($bits(item_entry_type)),
      .DEPTH (MAX_ITEMS)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (item_wr_en),
      .wr_addr (item_wr_addr[ADDR_W-1:0]),
      .wr_data (item_wr),
      .rd_addr (item_rd_addr[ADDR_W-1:0]),
      .rd_data (item_rd)
   );

   // Smallest tail per run length.
   lis_ram #(
      .WIDTH ($bits(tail_entry_type)),
      .DEPTH (MAX_ITEMS)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_wr_en),
      .wr_addr (tail_wr_addr[ADDR_W-1:0]),
      .wr_data (tail_wr),
      .rd_addr (tail_rd_addr[ADDR_W-1:0]),
      .rd_data (tail_rd)
   );

   // Item positions collected by the backward walk.
   lis_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ITEMS)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_wr_en),
      .wr_addr (chain_wr_addr[ADDR_W-1:0]),
      .wr_data (chain_wr),
      .rd_addr (chain_rd_addr[ADDR_W-1:0]),
      .rd_data (chain_rd)
   );

   // One lower-bound step: the tail read last cycle is compared with the item.
   always_comb begin
      cmp_le    = (value_ff <= tail_rd.value);
      lo_step   = cmp_le ? lo_ff : (mid_ff + CNT_W'(1));
      hi_step   = cmp_le ? mid_ff : hi_ff;
      step_sum  = {1'b0, lo_step} + {1'b0, hi_step};
      mid_step  = step_sum[CNT_W:1];
      first_sum = {1'b0, tail_count_ff};
      mid_first = first_sum[CNT_W:1];
      pos_plus  = pos_ff + CNT_W'(1);
   end

   // Walk step: the current position comes from the best item or from the
   // predecessor read in the previous cycle.
   always_comb begin
      walk_cur = (state_ff == ST_WALK_START) ? {1'b0, best_index_ff} : item_rd.predecessor;
      walk_go  = (walk_n_ff < best_length_ff) && (walk_cur < item_count_ff);
   end

   // Sequencer: next state, register updates and RAM accesses.
   always_comb begin
      state_in       = state_ff;
      tail_count_in  = tail_count_ff;
      item_count_in  = item_count_ff;
      best_length_in = best_length_ff;
      best_index_in  = best_index_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      value_in       = value_ff;
      final_in       = final_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      pos_in         = pos_ff;
      walk_n_in      = walk_n_ff;
      emit_k_in      = emit_k_ff;
      rsp_in         = rsp_ff;

      item_wr_en    = 1'b0;
      item_wr_addr  = item_count_ff;
      item_wr       = '{value: value_ff, predecessor: NO_PRED};
      item_rd_addr  = '0;
      tail_wr_en    = 1'b0;
      tail_wr_addr  = pos_ff;
      tail_wr       = '{value: value_ff, index: item_count_ff[IDX_W-1:0]};
      tail_rd_addr  = '0;
      chain_wr_en   = 1'b0;
      chain_wr_addr = walk_n_ff;
      chain_wr      = walk_cur[IDX_W-1:0];
      chain_rd_addr = emit_k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // The first probe is issued speculatively at the middle tail.
            tail_rd_addr = mid_first;
            if (req_valid) begin
               value_in = req_payload.value;
               final_in = req_payload.final_item;
               if (item_count_ff < CAPACITY) begin
                  lo_in  = '0;
                  hi_in  = tail_count_ff;
                  mid_in = mid_first;
                  pos_in = '0;
                  if (tail_count_ff == '0) begin
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else begin
                  dropped_in = 1'b1;
                  if (req_payload.final_item) begin
                     walk_n_in = '0;
                     state_in  = ST_WALK_START;
                  end
               end
            end
         end

         ST_SEARCH: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (lo_step < hi_step) begin
               mid_in       = mid_step;
               tail_rd_addr = mid_step;
            end else begin
               // Search done: fetch the tail one below for the predecessor.
               pos_in       = lo_step;
               tail_rd_addr = lo_step - CNT_W'(1);
               state_in     = ST_WRITE;
            end
         end

         ST_WRITE: begin
            item_wr_en = 1'b1;
            tail_wr_en = 1'b1;
            if (pos_ff != '0) begin
               item_wr.predecessor = {1'b0, tail_rd.index};
            end
            if (pos_plus > tail_count_ff) begin
               tail_count_in = pos_plus;
            end
            if (pos_plus >= best_length_ff) begin
               best_length_in = pos_plus;
               best_index_in  = item_count_ff[IDX_W-1:0];
            end
            item_count_in = item_count_ff + CNT_W'(1);
            walk_n_in     = '0;
            state_in      = final_ff ? ST_WALK_START : ST_IDLE;
         end

         ST_WALK_START, ST_WALK: begin
            item_rd_addr = walk_cur;
            if (walk_go) begin
               chain_wr_en = 1'b1;
               walk_n_in   = walk_n_ff + CNT_W'(1);
               state_in    = ST_WALK;
            end else if (walk_n_ff == '0) begin
               // Nothing to report: return to the cleared state.
               tail_count_in  = '0;
               item_count_in  = '0;
               best_length_in = '0;
               best_index_in  = '0;
               dropped_in     = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               emit_k_in = walk_n_ff - CNT_W'(1);
               state_in  = ST_EMIT_CHAIN;
            end
         end

         ST_EMIT_CHAIN: begin
            state_in = ST_EMIT_ITEM;
         end

         ST_EMIT_ITEM: begin
            item_rd_addr = {1'b0, chain_rd};
            state_in     = ST_EMIT_LOAD;
         end

         ST_EMIT_LOAD: begin
            // Hold the addresses so that the read data stays put while stalled.
            item_rd_addr = {1'b0, chain_rd};
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.element       = item_rd.value;
               rsp_in.element_index = chain_rd;
               rsp_in.run_length    = best_length_ff;
               rsp_in.overflowed    = dropped_ff;
               rsp_in.run_end       = (emit_k_ff == '0);
               rsp_valid_in         = 1'b1;
               if (emit_k_ff == '0) begin
                  tail_count_in  = '0;
                  item_count_in  = '0;
                  best_length_in = '0;
                  best_index_in  = '0;
                  dropped_in     = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  emit_k_in = emit_k_ff - CNT_W'(1);
                  state_in  = ST_EMIT_CHAIN;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tail_count_ff  <= '0;
         item_count_ff  <= '0;
         best_length_ff <= '0;
         best_index_ff  <= '0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         tail_count_ff  <= tail_count_in;
         item_count_ff  <= item_count_in;
         best_length_ff <= best_length_in;
         best_index_ff  <= best_index_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and output registers.
   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      final_ff  <= final_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      walk_n_ff <= walk_n_in;
      emit_k_ff <= emit_k_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : longest_increasing_subsequence_top
`default_nettype wire
